// ----- src/dsfe_pkg.sv -----
// Shared types, constants and frame-building functions for the DShot frame encoder.
`default_nettype none

package dsfe_pkg;

    localparam int unsigned FRAME_BITS = 16;
    localparam int unsigned CMD_W      = 11;
    localparam int unsigned QUOT_W     = 10;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned PROD_W     = SPEED_W + QUOT_W;

    localparam logic [QUOT_W-1:0] CMD_RANGE   = 10'd999;
    localparam logic [CMD_W:0]    CCW_OFFSET  = 12'd1001;
    localparam logic [CMD_W:0]    CMD_OFFSET  = 12'd48;
    localparam logic [CMD_W:0]    CMD_MAX     = 12'd2047;

    localparam logic [1:0] CFG_FULL_SCALE = 2'd0;
    localparam logic [1:0] CFG_DEADZONE   = 2'd1;
    localparam logic [1:0] CFG_ONE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_ZERO_WIDTH = 2'd3;

    typedef struct packed {
        logic [15:0] full_scale;
        logic [15:0] deadzone;
        logic [15:0] one_pulse_width;
        logic [15:0] zero_pulse_width;
    } t_cfg;

    typedef struct packed {
        logic                  channel;
        logic [FRAME_BITS-1:0] frame;
    } t_frame_item;

    // Turns a scaled speed (0..999) into a command with direction and offset.
    function automatic logic [CMD_W-1:0] finish_command(input logic [QUOT_W-1:0] quot,
                                                        input logic dir);
        logic [CMD_W:0] sum;
        logic [CMD_W:0] q_clamped;
        begin
            q_clamped = (quot > CMD_RANGE) ? {2'b00, CMD_RANGE} : {2'b00, quot};
            sum = q_clamped + (dir ? CCW_OFFSET : '0) + CMD_OFFSET;
            if (sum > CMD_MAX) begin
                sum = CMD_MAX;
            end
            finish_command = sum[CMD_W-1:0];
        end
    endfunction

    // Command in bits 15..5, telemetry bit clear, XOR of nibbles in bits 3..0.
    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [CMD_W-1:0] cmd);
        logic [CMD_W:0] payload;
        logic [3:0]     crc;
        begin
            payload = {cmd, 1'b0};
            crc = payload[3:0] ^ payload[7:4] ^ payload[11:8];
            build_frame = {cmd, 1'b0, crc};
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/dsfe_front.sv -----
// Front end: accepts requests, scales speed with a bit-serial divider, queues frames.
`default_nettype none

module dsfe_front
    import dsfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic        i_motor,
    input  wire logic [15:0] i_speed,
    input  wire logic        i_dir,
    input  wire logic [10:0] i_raw_command,
    output logic             o_push,
    output t_frame_item      o_item,
    input  wire logic        i_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [3:0]        r_step,  n_step;
    logic              r_bypass, n_bypass;
    logic [CMD_W-1:0]  r_cmd,    n_cmd;
    logic              r_motor,  n_motor;
    logic              r_dir,    n_dir;
    logic [15:0]       r_spd,    n_spd;
    logic [15:0]       r_rem,    n_rem;
    logic [QUOT_W-1:0] r_low,    n_low;

    logic              in_fire;
    logic [15:0]       spd_c;
    logic              dead;
    logic [PROD_W-1:0] prod;
    logic [16:0]       trial;
    logic              ge;
    logic [16:0]       diff;
    logic [CMD_W-1:0]  cmd_out;

    assign o_ready = (r_state == ST_IDLE) || ((r_state == ST_PUSH) && !i_full);
    assign in_fire = i_valid && o_ready;

    assign spd_c = (i_speed > i_cfg.full_scale) ? i_cfg.full_scale : i_speed;
    assign dead  = spd_c < i_cfg.deadzone;

    assign prod  = {{QUOT_W{1'b0}}, r_spd} * {{SPEED_W{1'b0}}, CMD_RANGE};

    // Restoring division step; the quotient fits ten bits because speed <= full scale.
    assign trial = {r_rem, r_low[QUOT_W-1]};
    assign ge    = trial >= {1'b0, i_cfg.full_scale};
    assign diff  = trial - {1'b0, i_cfg.full_scale};

    assign cmd_out = r_bypass ? r_cmd : finish_command(r_low, r_dir);
    assign o_push  = (r_state == ST_PUSH) && !i_full;
    assign o_item  = '{channel: r_motor, frame: build_frame(cmd_out)};

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_bypass = r_bypass;
        n_cmd    = r_cmd;
        n_motor  = r_motor;
        n_dir    = r_dir;
        n_spd    = r_spd;
        n_rem    = r_rem;
        n_low    = r_low;
        case (r_state)
            ST_IDLE: begin
            end
            ST_MUL: begin
                n_rem   = prod[PROD_W-1:QUOT_W];
                n_low   = prod[QUOT_W-1:0];
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem  = ge ? diff[15:0] : trial[15:0];
                n_low  = {r_low[QUOT_W-2:0], ge};
                n_step = r_step + 4'd1;
                if (r_step == 4'(QUOT_W - 1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (in_fire) begin
            n_motor  = i_motor;
            n_dir    = i_dir;
            n_spd    = spd_c;
            n_bypass = i_op || dead;
            n_cmd    = i_op ? i_raw_command : '0;
            n_low    = '0;
            // A zero full scale means a scaled speed of zero with no division.
            if (i_op || dead || (i_cfg.full_scale == 16'd0)) begin
                n_state = ST_PUSH;
            end else begin
                n_state = ST_MUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_step   <= n_step;
        r_bypass <= n_bypass;
        r_cmd    <= n_cmd;
        r_motor  <= n_motor;
        r_dir    <= n_dir;
        r_spd    <= n_spd;
        r_rem    <= n_rem;
        r_low    <= n_low;
    end

endmodule

`default_nettype wire

// ----- src/dsfe_fifo.sv -----
// Short frame queue between the front end and the pulse serializer.
`default_nettype none

module dsfe_fifo
    import dsfe_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_frame_item i_item,
    input  wire logic        i_pop,
    output t_frame_item      o_item,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_frame_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- src/dsfe_back.sv -----
// Back end: shifts each frame out MSB first as sixteen pulse widths into an output register.
`default_nettype none

module dsfe_back
    import dsfe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire t_frame_item i_item,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_channel,
    output logic [15:0]      o_pulse_width,
    output logic             o_last
);

    localparam int unsigned CNT_W = $clog2(FRAME_BITS);

    logic                  r_busy;
    logic [FRAME_BITS-1:0] r_shift;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_chan;
    logic                  r_out_valid;
    logic                  r_out_chan;
    logic [15:0]           r_out_width;
    logic                  r_out_last;

    logic                  can_load;
    logic                  emit_bit;

    assign can_load = !r_out_valid || i_ready;
    assign o_pop    = can_load && !r_busy && !i_empty;
    assign emit_bit = r_busy ? r_shift[FRAME_BITS-1] : i_item.frame[FRAME_BITS-1];

    assign o_valid       = r_out_valid;
    assign o_channel     = r_out_chan;
    assign o_pulse_width = r_out_width;
    assign o_last        = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (can_load) begin
            r_out_valid <= r_busy || !i_empty;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAME_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end else if (!i_empty) begin
                // The first bit of a new frame is loaded into the output register in the cycle it leaves the queue.
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(1);
            end
        end

        if (can_load) begin
            r_out_width <= emit_bit ? i_cfg.one_pulse_width : i_cfg.zero_pulse_width;
            r_out_chan  <= r_busy ? r_chan : i_item.channel;
            r_out_last  <= r_busy && (r_cnt == CNT_W'(FRAME_BITS - 1));
            if (r_busy) begin
                r_shift <= {r_shift[FRAME_BITS-2:0], 1'b0};
            end else begin
                r_shift <= {i_item.frame[FRAME_BITS-2:0], 1'b0};
                r_chan  <= i_item.channel;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/dshot_speed_frame_encoder.sv -----
// Top level of the DShot frame encoder: configuration registers, front end, queue, serializer.
// With the serializer idle, a speed request passes a multiply step, ten divider steps, the
// queue push and the output register before its first pulse; a raw command or stop skips
// to the push. The pulse serializer gives one output item per cycle unless i_m_tready
// stalls it. The front end overlaps the next item's division with the current frame.
// Reset is synchronous, active low: queue and handshake state clear, config takes defaults.
`default_nettype none

module dshot_speed_frame_encoder
    import dsfe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // speed[15:0], dir[16], raw_command[27:17], zeros
    input  wire logic [1:0]  i_s_tuser,   // op[0], motor[1]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // pulse_width[15:0]
    output logic [0:0]       o_m_tuser,   // channel[0]
    output logic             o_m_tlast
);

    t_cfg        r_cfg;
    logic        push, pop, full, empty;
    t_frame_item push_item, head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale       <= 16'd1000;
            r_cfg.deadzone         <= 16'd0;
            r_cfg.one_pulse_width  <= 16'd60;
            r_cfg.zero_pulse_width <= 16'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FULL_SCALE: r_cfg.full_scale       <= i_cfg_data;
                CFG_DEADZONE:   r_cfg.deadzone         <= i_cfg_data;
                CFG_ONE_WIDTH:  r_cfg.one_pulse_width  <= i_cfg_data;
                CFG_ZERO_WIDTH: r_cfg.zero_pulse_width <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dsfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_op          (i_s_tuser[0]),
        .i_motor       (i_s_tuser[1]),
        .i_speed       (i_s_tdata[15:0]),
        .i_dir         (i_s_tdata[16]),
        .i_raw_command (i_s_tdata[27:17]),
        .o_push        (push),
        .o_item        (push_item),
        .i_full        (full)
    );

    dsfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    dsfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item        (head_item),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_channel     (o_m_tuser[0]),
        .o_pulse_width (o_m_tdata),
        .o_last        (o_m_tlast)
    );

endmodule

`default_nettype wire
